// ===== rtl/core/mstt_pkg.sv =====
`timescale 1ns / 1ps

package mstt_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned MaxRes = 16;
  localparam int unsigned FireCntW = $clog2(MaxRes + 1);
  localparam logic [31:0] TimeMax = 32'h7FFF_FFFF;

  localparam logic [2:0] FUNC_ADD_ONESHOT  = 3'd0;
  localparam logic [2:0] FUNC_ADD_PERIODIC = 3'd1;
  localparam logic [2:0] FUNC_DESTROY      = 3'd2;
  localparam logic [2:0] FUNC_FIND         = 3'd3;
  localparam logic [2:0] FUNC_GET_NEXT     = 3'd4;
  localparam logic [2:0] FUNC_TICK         = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_WAIT   = 3'd3,
    ST_INACTIVE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_DESTROY,
    OP_FIND,
    OP_NEXT,
    OP_TICK,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DECIDE,
    B_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] timeout_ms;
    logic [7:0]  handler_id;
    logic [15:0] tag;
    logic [3:0]  slot;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] next_ms;
    logic        fired;
    logic [7:0]  handler_out;
    logic [15:0] tag_out;
    logic        wait_expired;
    logic        last;
  } result_t;

  // Classified command handed from the front end to the execution unit.
  typedef struct packed {
    op_e         op;
    logic        periodic;
    logic [31:0] tmo;
    logic [7:0]  handler;
    logic [15:0] tag;
    logic [3:0]  slot;
    logic [15:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic        periodic;
    logic [31:0] deadline;
    logic [31:0] period;
    logic [7:0]  handler;
    logic [15:0] tag;
    logic [31:0] age;
  } slot_rec_t;

endpackage

// ===== rtl/core/mstt_front.sv =====
`timescale 1ns / 1ps

module mstt_front (
  input  mstt_pkg::item_t item_i,
  output mstt_pkg::cmd_t  cmd_o
);

  always_comb begin
    cmd_o.periodic = (item_i.func == mstt_pkg::FUNC_ADD_PERIODIC);
    cmd_o.handler  = item_i.handler_id;
    cmd_o.tag      = item_i.tag;
    cmd_o.slot     = item_i.slot;
    cmd_o.elapsed  = item_i.elapsed_ms;
    // Long timeouts saturate so that signed time differences stay meaningful.
    cmd_o.tmo = (item_i.timeout_ms > mstt_pkg::TimeMax) ? mstt_pkg::TimeMax
                                                        : item_i.timeout_ms;
    unique case (item_i.func)
      mstt_pkg::FUNC_ADD_ONESHOT,
      mstt_pkg::FUNC_ADD_PERIODIC: cmd_o.op = mstt_pkg::OP_ADD;
      mstt_pkg::FUNC_DESTROY:      cmd_o.op = mstt_pkg::OP_DESTROY;
      mstt_pkg::FUNC_FIND:         cmd_o.op = mstt_pkg::OP_FIND;
      mstt_pkg::FUNC_GET_NEXT:     cmd_o.op = mstt_pkg::OP_NEXT;
      mstt_pkg::FUNC_TICK:         cmd_o.op = mstt_pkg::OP_TICK;
      default:                     cmd_o.op = mstt_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/mstt_queue.sv =====
`timescale 1ns / 1ps

module mstt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mstt_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output mstt_pkg::cmd_t data_o
);

  mstt_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/mstt_back.sv =====
`timescale 1ns / 1ps

module mstt_back #(
  parameter int unsigned NUM_SLOTS = mstt_pkg::NumSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  mstt_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  output logic              strobe_o,
  output mstt_pkg::result_t result_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = mstt_pkg::FireCntW;

  mstt_pkg::slot_rec_t    mem [NUM_SLOTS];
  mstt_pkg::slot_rec_t    rd_q;

  mstt_pkg::back_state_e  state_q, state_d;
  mstt_pkg::cmd_t         cmd_q, cmd_d;
  logic [31:0]            now_q, now_d, seq_q, seq_d, wdl_q, wdl_d;
  logic                   warm_q, warm_d;
  logic [NUM_SLOTS-1:0]   active_q, active_d, done_q, done_d;
  logic [SW-1:0]          addr_q, addr_d, idx_q, idx_d;
  logic                   vld_q, vld_d;
  logic                   have_q, have_d;
  logic [SW-1:0]          best_q, best_d;
  mstt_pkg::slot_rec_t    brec_q, brec_d;
  logic [31:0]            bestd_q, bestd_d;
  logic signed [31:0]     low_q, low_d;
  logic                   pend_q, pend_d;
  logic [SW-1:0]          pidx_q, pidx_d;
  logic [7:0]             phnd_q, phnd_d;
  logic [15:0]            ptag_q, ptag_d;
  logic [CW-1:0]          fcnt_q, fcnt_d;
  logic                   strobe_q, strobe_d;
  mstt_pkg::result_t      res_q, res_d;

  logic                   we;
  logic [SW-1:0]          wa;
  mstt_pkg::slot_rec_t    wd;

  logic [31:0]            nw, age_d;
  logic signed [31:0]     rem, wrem;
  logic                   cand, free_f, wexp;
  logic [SW-1:0]          free_idx, sidx;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[addr_q];
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    now_d    = now_q;
    seq_d    = seq_q;
    wdl_d    = wdl_q;
    warm_d   = warm_q;
    active_d = active_q;
    done_d   = done_q;
    addr_d   = addr_q;
    idx_d    = addr_q;
    vld_d    = 1'b0;
    have_d   = have_q;
    best_d   = best_q;
    brec_d   = brec_q;
    bestd_d  = bestd_q;
    low_d    = low_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    phnd_d   = phnd_q;
    ptag_d   = ptag_q;
    fcnt_d   = fcnt_q;
    strobe_d = 1'b0;
    res_d    = '0;
    res_d.last = 1'b1;
    pop_o    = 1'b0;
    we       = 1'b0;
    wa       = best_q;
    wd       = brec_q;

    nw   = now_q + {16'd0, cmd_i.elapsed};
    wrem = signed'(wdl_q - now_q);
    wexp = warm_q && (wrem <= 0);

    free_f   = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!free_f && !active_q[i]) begin
        free_f   = 1'b1;
        free_idx = SW'(i);
      end
    end
    sidx = SW'(cmd_i.slot);

    // Compare stage of the slot scan.
    rem   = signed'(rd_q.deadline - now_q);
    age_d = seq_q - rd_q.age;
    cand  = 1'b0;
    if (vld_q && active_q[idx_q]) begin
      priority case (cmd_q.op)
        mstt_pkg::OP_FIND: cand = (rd_q.tag == cmd_q.tag) && (!have_q || age_d < bestd_q);
        mstt_pkg::OP_NEXT: cand = !have_q || rem < low_q;
        mstt_pkg::OP_TICK: cand = !done_q[idx_q] && (rem <= 0)
                                  && (!have_q || age_d < bestd_q);
        default:           cand = 1'b0;
      endcase
    end
    if (cand) begin
      have_d  = 1'b1;
      best_d  = idx_q;
      brec_d  = rd_q;
      bestd_d = age_d;
      low_d   = rem;
    end

    unique case (state_q)
      mstt_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = cmd_i;
          now_d  = nw;
          have_d = 1'b0;
          addr_d = '0;
          unique case (cmd_i.op)
            mstt_pkg::OP_ADD: begin
              strobe_d = 1'b1;
              if (!free_f) begin
                res_d.status = mstt_pkg::ST_FULL;
              end else begin
                we               = 1'b1;
                wa               = free_idx;
                wd.periodic      = cmd_i.periodic;
                wd.deadline      = nw + cmd_i.tmo;
                wd.period        = cmd_i.tmo;
                wd.handler       = cmd_i.handler;
                wd.tag           = cmd_i.tag;
                wd.age           = seq_q;
                active_d[free_idx] = 1'b1;
                seq_d            = seq_q + 32'd1;
                res_d.status     = mstt_pkg::ST_OK;
                res_d.slot_out   = 4'(free_idx);
              end
            end
            mstt_pkg::OP_DESTROY: begin
              strobe_d = 1'b1;
              if ((32'(cmd_i.slot) >= NUM_SLOTS) || !active_q[sidx]) begin
                res_d.status = mstt_pkg::ST_INACTIVE;
              end else begin
                active_d[sidx] = 1'b0;
                res_d.status   = mstt_pkg::ST_OK;
                res_d.slot_out = cmd_i.slot;
              end
            end
            mstt_pkg::OP_FIND: state_d = mstt_pkg::B_SCAN;
            mstt_pkg::OP_NEXT: begin
              if (cmd_i.tmo == 32'd0 && active_q == '0) begin
                strobe_d     = 1'b1;
                res_d.status = mstt_pkg::ST_NO_WAIT;
              end else begin
                state_d = mstt_pkg::B_SCAN;
                if (cmd_i.tmo != 32'd0) begin
                  wdl_d  = nw + cmd_i.tmo;
                  warm_d = 1'b1;
                  have_d = 1'b1;
                  low_d  = signed'(cmd_i.tmo);
                end else begin
                  warm_d = 1'b0;
                end
              end
            end
            mstt_pkg::OP_TICK: begin
              state_d = mstt_pkg::B_SCAN;
              done_d  = '0;
              fcnt_d  = '0;
              pend_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      mstt_pkg::B_SCAN: begin
        vld_d  = 1'b1;
        addr_d = addr_q + SW'(1);
        if (addr_q == SW'(NUM_SLOTS - 1)) begin
          state_d = mstt_pkg::B_DRAIN;
        end
      end
      mstt_pkg::B_DRAIN: begin
        state_d = mstt_pkg::B_DECIDE;
      end
      mstt_pkg::B_DECIDE: begin
        state_d = mstt_pkg::B_IDLE;
        priority case (cmd_q.op)
          mstt_pkg::OP_FIND: begin
            strobe_d = 1'b1;
            if (have_q) begin
              res_d.status   = mstt_pkg::ST_OK;
              res_d.slot_out = 4'(best_q);
            end else begin
              res_d.status = mstt_pkg::ST_NOT_FOUND;
            end
          end
          mstt_pkg::OP_NEXT: begin
            strobe_d      = 1'b1;
            res_d.status  = mstt_pkg::ST_OK;
            res_d.next_ms = (low_q < 0) ? 32'd0 : low_q;
          end
          default: begin
            if (have_q) begin
              if (brec_q.periodic) begin
                we          = 1'b1;
                wd.deadline = now_q + brec_q.period;
              end else begin
                active_d[best_q] = 1'b0;
              end
              done_d[best_q] = 1'b1;
              fcnt_d         = fcnt_q + CW'(1);
              if (pend_q) begin
                strobe_d          = 1'b1;
                res_d.fired       = 1'b1;
                res_d.slot_out    = 4'(pidx_q);
                res_d.handler_out = phnd_q;
                res_d.tag_out     = ptag_q;
                res_d.last        = 1'b0;
              end
              pend_d = 1'b1;
              pidx_d = best_q;
              phnd_d = brec_q.handler;
              ptag_d = brec_q.tag;
              have_d = 1'b0;
              addr_d = '0;
              if (fcnt_q + CW'(1) == CW'(mstt_pkg::MaxRes)) begin
                state_d = mstt_pkg::B_FLUSH;
              end else begin
                state_d = mstt_pkg::B_SCAN;
              end
            end else begin
              strobe_d           = 1'b1;
              res_d.wait_expired = wexp;
              if (pend_q) begin
                res_d.fired       = 1'b1;
                res_d.slot_out    = 4'(pidx_q);
                res_d.handler_out = phnd_q;
                res_d.tag_out     = ptag_q;
              end
            end
          end
        endcase
      end
      mstt_pkg::B_FLUSH: begin
        state_d            = mstt_pkg::B_IDLE;
        strobe_d           = 1'b1;
        res_d.fired        = 1'b1;
        res_d.slot_out     = 4'(pidx_q);
        res_d.handler_out  = phnd_q;
        res_d.tag_out      = ptag_q;
        res_d.wait_expired = wexp;
      end
      default: state_d = mstt_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mstt_pkg::B_IDLE;
      now_q    <= '0;
      seq_q    <= '0;
      wdl_q    <= '0;
      warm_q   <= 1'b0;
      active_q <= '0;
      done_q   <= '0;
      addr_q   <= '0;
      vld_q    <= 1'b0;
      have_q   <= 1'b0;
      pend_q   <= 1'b0;
      fcnt_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      seq_q    <= seq_d;
      wdl_q    <= wdl_d;
      warm_q   <= warm_d;
      active_q <= active_d;
      done_q   <= done_d;
      addr_q   <= addr_d;
      vld_q    <= vld_d;
      have_q   <= have_d;
      pend_q   <= pend_d;
      fcnt_q   <= fcnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    best_q  <= best_d;
    brec_q  <= brec_d;
    bestd_q <= bestd_d;
    low_q   <= low_d;
    pidx_q  <= pidx_d;
    phnd_q  <= phnd_d;
    ptag_q  <= ptag_d;
    res_q   <= res_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

// ===== rtl/core/multi_slot_software_timer_table_core.sv =====
`timescale 1ns / 1ps

// Timer table with NUM_SLOTS one-shot or periodic slots and a wrapping 32-bit
// millisecond clock. An item is taken whenever start_i is high and busy_o is
// low; a two-beat command queue sits between the decoder and the execution
// unit, so busy_o rises only when both queue entries are waiting. Results come
// out at most one beat per cycle on result_o, marked by result_strobe_o, and
// must be taken in that cycle since the receiver cannot hold them off; last
// marks the final beat of an item. Add and destroy are carried out from the
// idle state of the execution unit. Find and get-next read every slot record
// once through the read port of the slot memory; a get-next with a zero
// timeout and an empty table answers no-wait without a scan. A tick repeats
// that scan once per expired timer plus a closing scan, since each scan picks
// the newest remaining expired slot; a tick that fires the full 16 ends in a
// flush state instead of a closing scan, and its last beat leaves from there.
// Unknown function codes only advance time.
module multi_slot_software_timer_table_core #(
  parameter int unsigned NUM_SLOTS = mstt_pkg::NumSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mstt_pkg::item_t   item_i,
  output logic              result_strobe_o,
  output mstt_pkg::result_t result_o
);

  mstt_pkg::cmd_t front_cmd;
  mstt_pkg::cmd_t queue_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // Decode and saturate the incoming beat.
  mstt_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  mstt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start_i && !q_full),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .data_o  (queue_cmd)
  );

  // Execution unit: owns the clock, the slot store and the result register.
  mstt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .cmd_i    (queue_cmd),
    .pop_o    (q_pop),
    .strobe_o (result_strobe_o),
    .result_o (result_o)
  );

  assign busy_o = q_full;

endmodule

// ===== tb/timer_table_checker.sv =====
`timescale 1ns / 1ps

module timer_table_checker #(
  parameter int unsigned NUM_SLOTS = mstt_pkg::NumSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  mstt_pkg::item_t   item_i,
  input  logic              result_strobe_i,
  input  mstt_pkg::result_t result_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [31:0]         clock_ms;
  logic                live [NUM_SLOTS];
  logic                repeats [NUM_SLOTS];
  logic [31:0]         due [NUM_SLOTS];
  logic [31:0]         period [NUM_SLOTS];
  logic [7:0]          handler [NUM_SLOTS];
  logic [15:0]         label [NUM_SLOTS];
  logic [31:0]         birth [NUM_SLOTS];
  logic [31:0]         add_count;
  logic [31:0]         wait_due;
  logic                wait_on;
  mstt_pkg::result_t   expected_beats[$];

  // Signed distance from the present time to a deadline.
  function automatic logic signed [31:0] time_left(logic [31:0] deadline);
    return $signed(deadline - clock_ms);
  endfunction

  function automatic mstt_pkg::result_t beat(logic [2:0] st, logic [3:0] sl);
    mstt_pkg::result_t r;
    r = '0;
    r.status = st;
    r.slot_out = sl;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_item(mstt_pkg::item_t it);
    logic [31:0] tmo;
    int found;
    logic [31:0] best_d;
    logic signed [32:0] low;
    logic have;
    logic any;
    int order [NUM_SLOTS];
    int n;
    int j;
    logic [31:0] d;
    logic wexp;
    mstt_pkg::result_t r;
    tmo = (it.timeout_ms > mstt_pkg::TimeMax) ? mstt_pkg::TimeMax : it.timeout_ms;
    clock_ms = clock_ms + 32'(it.elapsed_ms);
    found = -1;
    best_d = '0;
    n = 0;
    case (it.func)
      mstt_pkg::FUNC_ADD_ONESHOT, mstt_pkg::FUNC_ADD_PERIODIC: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!live[i]) found = i;
        if (found < 0) begin
          expected_beats.push_back(beat(mstt_pkg::ST_FULL, '0));
        end else begin
          live[found] = 1'b1;
          repeats[found] = (it.func == mstt_pkg::FUNC_ADD_PERIODIC);
          due[found] = clock_ms + tmo;
          period[found] = tmo;
          handler[found] = it.handler_id;
          label[found] = it.tag;
          birth[found] = add_count;
          add_count = add_count + 1;
          expected_beats.push_back(beat(mstt_pkg::ST_OK, 4'(found)));
        end
      end
      mstt_pkg::FUNC_DESTROY: begin
        if (it.slot >= NUM_SLOTS || !live[it.slot]) begin
          expected_beats.push_back(beat(mstt_pkg::ST_INACTIVE, '0));
        end else begin
          live[it.slot] = 1'b0;
          expected_beats.push_back(beat(mstt_pkg::ST_OK, it.slot));
        end
      end
      mstt_pkg::FUNC_FIND: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (live[i] && label[i] == it.tag) begin
            d = add_count - birth[i];
            if (found < 0 || d < best_d) begin
              found = i;
              best_d = d;
            end
          end
        end
        if (found < 0) expected_beats.push_back(beat(mstt_pkg::ST_NOT_FOUND, '0));
        else expected_beats.push_back(beat(mstt_pkg::ST_OK, 4'(found)));
      end
      mstt_pkg::FUNC_GET_NEXT: begin
        any = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) if (live[i]) any = 1'b1;
        if (tmo == 0 && !any) begin
          expected_beats.push_back(beat(mstt_pkg::ST_NO_WAIT, '0));
        end else begin
          have = 1'b0;
          low = '0;
          if (tmo != 0) begin
            wait_due = clock_ms + tmo;
            wait_on = 1'b1;
            low = $signed({1'b0, tmo});
            have = 1'b1;
          end else begin
            wait_on = 1'b0;
          end
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (live[i] && (!have || 33'(time_left(due[i])) < low)) begin
              low = 33'(time_left(due[i]));
              have = 1'b1;
            end
          end
          if (low < 0) low = '0;
          r = beat(mstt_pkg::ST_OK, '0);
          r.next_ms = low[31:0];
          expected_beats.push_back(r);
        end
      end
      mstt_pkg::FUNC_TICK: begin
        // Expired slots sorted newest first by insertion.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (live[i] && time_left(due[i]) <= 0) begin
            d = add_count - birth[i];
            j = n;
            while (j > 0 && (add_count - birth[order[j - 1]]) > d) begin
              order[j] = order[j - 1];
              j--;
            end
            order[j] = i;
            n++;
          end
        end
        if (n > mstt_pkg::MaxRes) n = mstt_pkg::MaxRes;
        for (int k = 0; k < n; k++) begin
          if (repeats[order[k]]) due[order[k]] = clock_ms + period[order[k]];
          else live[order[k]] = 1'b0;
        end
        wexp = wait_on && time_left(wait_due) <= 0;
        if (n == 0) begin
          r = beat(mstt_pkg::ST_OK, '0);
          r.wait_expired = wexp;
          expected_beats.push_back(r);
        end
        for (int k = 0; k < n; k++) begin
          r = beat(mstt_pkg::ST_OK, 4'(order[k]));
          r.fired = 1'b1;
          r.handler_out = handler[order[k]];
          r.tag_out = label[order[k]];
          r.last = (k == n - 1);
          r.wait_expired = (k == n - 1) ? wexp : 1'b0;
          expected_beats.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  assign pending_o = expected_beats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mstt_pkg::result_t want;
    if (!rst_ni) begin
      clock_ms = '0;
      add_count = '0;
      wait_due = '0;
      wait_on = 1'b0;
      fail_count_o <= 0;
      for (int i = 0; i < NUM_SLOTS; i++) live[i] = 1'b0;
      expected_beats.delete();
    end else begin
      if (result_strobe_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_beats.pop_front();
          if (want !== result_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, result_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) predict_item(item_i);
    end
  end
endmodule

// ===== tb/tb_multi_slot_software_timer_table_core.sv =====
`timescale 1ns / 1ps

module tb_multi_slot_software_timer_table_core;

  localparam int WatchdogLimit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  mstt_pkg::item_t   item_i = '0;
  logic              result_strobe_o;
  mstt_pkg::result_t result_o;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multi_slot_software_timer_table_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .result_strobe_o(result_strobe_o), .result_o(result_o)
  );

  // The checker watches both channels and keeps its own copy of the table.
  timer_table_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .item_i(item_i), .result_strobe_i(result_strobe_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The watchdog counts cycles in which neither an item nor a result beat
  // is accepted. A full tick scan is far below the limit.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it. The start line is
  // lowered only when a gap is wanted, so back-to-back beats stay high.
  task automatic send_item(mstt_pkg::item_t it, int gap);
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic mstt_pkg::item_t make_item(logic [2:0] fn, logic [31:0] tmo,
                                                logic [15:0] tag, logic [3:0] sl,
                                                logic [15:0] el);
    mstt_pkg::item_t it;
    it.func = fn;
    it.timeout_ms = tmo;
    it.handler_id = 8'($urandom);
    it.tag = tag;
    it.slot = sl;
    it.elapsed_ms = el;
    return it;
  endfunction

  // Mostly short timeouts and small steps of time so that timers really
  // expire; occasionally the full range of every field.
  function automatic mstt_pkg::item_t random_item();
    mstt_pkg::item_t it;
    int p;
    p = $urandom_range(0, 99);
    it = make_item(mstt_pkg::FUNC_TICK, 32'($urandom_range(0, 300)),
                   16'($urandom_range(0, 7)), 4'($urandom),
                   16'($urandom_range(0, 60)));
    if (p < 30) begin
      it.func = ($urandom_range(0, 1) != 0) ? mstt_pkg::FUNC_ADD_PERIODIC
                                            : mstt_pkg::FUNC_ADD_ONESHOT;
    end
    else if (p < 42) it.func = mstt_pkg::FUNC_DESTROY;
    else if (p < 52) it.func = mstt_pkg::FUNC_FIND;
    else if (p < 64) it.func = mstt_pkg::FUNC_GET_NEXT;
    else if (p < 96) it.func = mstt_pkg::FUNC_TICK;
    else it.func = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) == 0) begin
      it.timeout_ms = $urandom;
      it.tag = 16'($urandom);
      it.elapsed_ms = 16'($urandom);
    end
    if ($urandom_range(0, 5) == 0) it.timeout_ms = '0;
    return it;
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table cases, both extremes of the fields, a full
    // table, long timeouts that saturate and unknown function codes.
    send_item(make_item(mstt_pkg::FUNC_GET_NEXT, '0, '0, '0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_TICK, '0, '0, '0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_FIND, '0, 16'hFFFF, '0, '0), 1);
    send_item(make_item(mstt_pkg::FUNC_DESTROY, '0, '0, 4'hF, 16'hFFFF), 0);
    send_item(make_item(mstt_pkg::FUNC_ADD_PERIODIC, 32'hFFFF_FFFF, 16'hFFFF, '0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_ADD_ONESHOT, '0, 16'hFFFF, '0, '0), 2);
    for (int i = 0; i < 15; i++)
      send_item(make_item((i % 2) ? mstt_pkg::FUNC_ADD_PERIODIC
                                  : mstt_pkg::FUNC_ADD_ONESHOT,
                          32'(i * 3), 16'(i % 3), '0, 16'd1), 0);
    send_item(make_item(mstt_pkg::FUNC_FIND, '0, 16'hFFFF, '0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_GET_NEXT, 32'hFFFF_FFFF, '0, '0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_TICK, '0, '0, '0, 16'd100), 0);
    send_item(make_item(3'd7, '0, '0, '0, 16'hFFFF), 0);
    send_item(make_item(mstt_pkg::FUNC_DESTROY, '0, '0, 4'd0, '0), 0);
    send_item(make_item(mstt_pkg::FUNC_TICK, '0, '0, '0, 16'hFFFF), 3);

    for (int n = 0; n < 155; n++) send_item(random_item(), pick_gap());
    start_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (4 * (mstt_pkg::NumSlotsDefault + 3)) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
